// ----- design/ssrg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_pkg: shared types and constants
// Command codes, register indexes, work item and configuration structs.
// ----------------------------------------------------------------------------
package ssrg_pkg;

    // command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_FLOW  = 2'd1,
        CMD_STOP      = 2'd2,
        CMD_CLEAR_POS = 2'd3
    } cmd_kind_t;

    // configuration register indexes
    localparam logic [1:0] REG_FLOW_GAIN = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_RAMP_RATE = 2'd2;

    localparam logic [23:0] FLOW_GAIN_RESET = 24'd932067;
    localparam logic [23:0] MAX_SPEED_RESET = 24'd1024000;
    localparam logic [15:0] RAMP_RATE_RESET = 16'd2000;

    // one step in units of 1/256 step-us
    localparam logic [40:0] STEP_UNIT = 41'd256000000;

    // limit = floor(4 * p / 15625), p = ramp_rate * elapsed_us
    localparam logic [13:0] LIMIT_DIVISOR = 14'd15625;
    // floor(2^36 / 15625), used with a right shift by 34
    localparam logic [22:0] LIMIT_RECIP   = 23'd4398046;
    localparam int          LIMIT_SHIFT   = 34;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [23:0] flow_gain;
        logic [23:0] max_speed;
        logic [15:0] ramp_rate;
    } cfg_t;

    // classified item handed from the front to the back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] dt;
        logic [23:0] target;
        logic [20:0] limit;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // what the phase stage does with an item
    typedef enum logic [1:0] {
        PH_HOLD    = 2'd0,
        PH_ADVANCE = 2'd1,
        PH_HALT    = 2'd2,
        PH_CLEAR   = 2'd3
    } phase_op_t;

endpackage

// ----- design/ssrg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_front: command intake and state-free arithmetic
// Classifies commands, converts flow to a clamped target and the ramp limit.
// ----------------------------------------------------------------------------
module ssrg_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ssrg_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_cmd,
    input  logic [15:0]          in_flow,
    input  logic [15:0]          in_dt,
    input  ssrg_pkg::q_stat_t    q_stat,
    output logic                 push,
    output ssrg_pkg::work_t      push_data
);

    logic adv;

    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    ssrg_pkg::cmd_kind_t   s1_kind_reg, s2_kind_reg, s3_kind_reg;
    logic [15:0]           s1_dt_reg, s2_dt_reg, s3_dt_reg;
    logic [31:0]           s1_prod_reg, s2_prod_reg;
    logic [39:0]           s1_flow_reg;
    logic [20:0]           s2_est_reg, s3_est_reg;
    logic [23:0]           s2_target_reg, s3_target_reg;
    logic [33:0]           s3_scaled_reg;

    ssrg_pkg::cmd_kind_t   kind_next;
    logic [54:0]           est_full;
    logic [31:0]           flow_shift;
    logic [34:0]           est_back;
    logic [34:0]           rem;

    assign adv      = !s3_valid_reg || !q_stat.full;
    assign in_ready = adv;
    assign push     = s3_valid_reg && !q_stat.full;

    // set flow with zero rate behaves as stop
    always_comb begin
        unique case (ssrg_pkg::cmd_kind_t'(in_cmd))
            ssrg_pkg::CMD_TICK:      kind_next = ssrg_pkg::CMD_TICK;
            ssrg_pkg::CMD_SET_FLOW:  kind_next = (in_flow == 16'd0) ? ssrg_pkg::CMD_STOP
                                                                    : ssrg_pkg::CMD_SET_FLOW;
            ssrg_pkg::CMD_STOP:      kind_next = ssrg_pkg::CMD_STOP;
            ssrg_pkg::CMD_CLEAR_POS: kind_next = ssrg_pkg::CMD_CLEAR_POS;
            default:                 kind_next = ssrg_pkg::CMD_TICK;
        endcase
    end

    assign est_full   = 55'(s1_prod_reg) * 55'(ssrg_pkg::LIMIT_RECIP);
    assign flow_shift = s1_flow_reg[39:8];
    assign est_back   = 35'(s3_est_reg) * 35'(ssrg_pkg::LIMIT_DIVISOR);
    assign rem        = {1'b0, s3_scaled_reg} - est_back;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // products
            s1_kind_reg   <= kind_next;
            s1_dt_reg     <= in_dt;
            s1_prod_reg   <= 32'(cfg.ramp_rate) * 32'(in_dt);
            s1_flow_reg   <= 40'(in_flow) * 40'(cfg.flow_gain);
            // reciprocal estimate and target clamp
            s2_kind_reg   <= s1_kind_reg;
            s2_dt_reg     <= s1_dt_reg;
            s2_prod_reg   <= s1_prod_reg;
            s2_est_reg    <= est_full[54:ssrg_pkg::LIMIT_SHIFT];
            s2_target_reg <= (flow_shift > 32'(cfg.max_speed)) ? cfg.max_speed
                                                               : flow_shift[23:0];
            // correction happens on the way out
            s3_kind_reg   <= s2_kind_reg;
            s3_dt_reg     <= s2_dt_reg;
            s3_est_reg    <= s2_est_reg;
            s3_target_reg <= s2_target_reg;
            s3_scaled_reg <= {s2_prod_reg, 2'b00};
        end
    end

    // estimate is the quotient or one below it
    always_comb begin
        push_data.kind   = s3_kind_reg;
        push_data.dt     = s3_dt_reg;
        push_data.target = s3_target_reg;
        push_data.limit  = (rem >= 35'(ssrg_pkg::LIMIT_DIVISOR)) ? s3_est_reg + 21'd1
                                                                : s3_est_reg;
    end

endmodule

// ----- design/ssrg_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_queue: small work queue
// Four-entry first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module ssrg_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ssrg_pkg::work_t      push_data,
    input  logic                 pop,
    output ssrg_pkg::work_t      pop_data,
    output ssrg_pkg::q_stat_t    q_stat
);

    ssrg_pkg::work_t                   mem_reg [ssrg_pkg::QUEUE_DEPTH];
    logic [ssrg_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [ssrg_pkg::QUEUE_AW:0]       count_reg, count_next;

    assign q_stat.full  = (count_reg == (ssrg_pkg::QUEUE_AW+1)'(ssrg_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/ssrg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrg_back: speed ramp and step generation
// Applies commands to the speed state, then runs the step phase accumulator.
// ----------------------------------------------------------------------------
module ssrg_back #(
    parameter int POSITION_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [23:0]          max_speed,
    input  ssrg_pkg::q_stat_t    q_stat,
    input  ssrg_pkg::work_t      pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_running,
    output logic                 out_pulse,
    output logic [23:0]          out_applied,
    output logic [23:0]          out_target,
    output logic [31:0]          out_position
);

    logic adv;

    // speed state
    logic        run_reg, run_next;
    logic [23:0] goal_reg, goal_next;
    logic [23:0] ramped_reg, ramped_next;

    // ramp stage
    logic                  b1_valid_reg;
    ssrg_pkg::phase_op_t   b1_op_reg, op_next;
    logic [15:0]           b1_dt_reg;
    logic                  b1_run_reg;
    logic [23:0]           b1_ramped_reg, b1_goal_reg;

    // product stage
    logic                  b2_valid_reg;
    ssrg_pkg::phase_op_t   b2_op_reg;
    logic [39:0]           b2_prod_reg;
    logic                  b2_run_reg;
    logic [23:0]           b2_ramped_reg, b2_goal_reg;

    // phase stage and output
    logic [27:0]              phase_reg, phase_next;
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic                     pulse_next;
    logic                     out_valid_reg, out_running_reg, out_pulse_reg;
    logic [23:0]              out_applied_reg, out_target_reg;

    logic [23:0] err;
    logic [23:0] slewed;
    logic        snap;
    logic [40:0] phase_sum, phase_left;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !q_stat.empty;

    // ramp toward the goal, snapping when the limit is zero or covers the error
    always_comb begin
        if (goal_reg >= ramped_reg) begin
            err    = goal_reg - ramped_reg;
            slewed = ramped_reg + pop_data.limit;
        end else begin
            err    = ramped_reg - goal_reg;
            slewed = ramped_reg - pop_data.limit;
        end
        snap = (pop_data.limit == 21'd0) || (24'(err) <= 24'(pop_data.limit));
    end

    always_comb begin
        run_next    = run_reg;
        goal_next   = goal_reg;
        ramped_next = ramped_reg;
        op_next     = ssrg_pkg::PH_HOLD;
        unique case (pop_data.kind)
            ssrg_pkg::CMD_TICK: begin
                if (run_reg) begin
                    ramped_next = snap ? goal_reg : slewed;
                    if (ramped_next > max_speed) begin
                        ramped_next = max_speed;
                    end
                    op_next = ssrg_pkg::PH_ADVANCE;
                end
            end
            ssrg_pkg::CMD_SET_FLOW: begin
                if (!run_reg) begin
                    ramped_next = '0;
                end
                goal_next = pop_data.target;
                run_next  = 1'b1;
            end
            ssrg_pkg::CMD_STOP: begin
                run_next    = 1'b0;
                goal_next   = '0;
                ramped_next = '0;
                op_next     = ssrg_pkg::PH_HALT;
            end
            ssrg_pkg::CMD_CLEAR_POS: begin
                op_next = ssrg_pkg::PH_CLEAR;
            end
            default: begin
                op_next = ssrg_pkg::PH_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= 1'b0;
            goal_reg   <= '0;
            ramped_reg <= '0;
        end else if (pop) begin
            run_reg    <= run_next;
            goal_reg   <= goal_next;
            ramped_reg <= ramped_next;
        end
    end

    // phase accumulate with at most one step per tick
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        pulse_next = 1'b0;
        phase_sum  = 41'(phase_reg) + 41'(b2_prod_reg);
        phase_left = phase_sum - ssrg_pkg::STEP_UNIT;
        case (b2_op_reg)
            ssrg_pkg::PH_ADVANCE: begin
                if (phase_sum >= ssrg_pkg::STEP_UNIT) begin
                    pulse_next = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (phase_left >= ssrg_pkg::STEP_UNIT) begin
                        phase_next = 28'(ssrg_pkg::STEP_UNIT - 41'd1);
                    end else begin
                        phase_next = phase_left[27:0];
                    end
                end else begin
                    phase_next = phase_sum[27:0];
                end
            end
            ssrg_pkg::PH_HALT:  phase_next = '0;
            ssrg_pkg::PH_CLEAR: count_next = '0;
            default:            phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            count_reg     <= '0;
        end else if (adv) begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
            if (b2_valid_reg) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_op_reg       <= op_next;
            b1_dt_reg       <= pop_data.dt;
            b1_run_reg      <= run_next;
            b1_ramped_reg   <= ramped_next;
            b1_goal_reg     <= goal_next;
            b2_op_reg       <= b1_valid_reg ? b1_op_reg : ssrg_pkg::PH_HOLD;
            b2_prod_reg     <= 40'(b1_ramped_reg) * 40'(b1_dt_reg);
            b2_run_reg      <= b1_run_reg;
            b2_ramped_reg   <= b1_ramped_reg;
            b2_goal_reg     <= b1_goal_reg;
            out_running_reg <= b2_run_reg;
            out_pulse_reg   <= pulse_next;
            out_applied_reg <= b2_ramped_reg;
            out_target_reg  <= b2_goal_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_running  = out_running_reg;
    assign out_pulse    = out_pulse_reg;
    assign out_applied  = out_applied_reg;
    assign out_target   = out_target_reg;
    assign out_position = 32'(count_reg);

    // a stopped pump holds no speed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !run_reg |-> (goal_reg == '0) && (ramped_reg == '0))
        else $error("speed held while stopped");

    // leftover phase always stays below one step
    assert property (@(posedge aclk) disable iff (!aresetn)
        41'(phase_reg) < ssrg_pkg::STEP_UNIT)
        else $error("phase reached a full step");

    // a step is only issued while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_pulse_reg |-> out_running_reg)
        else $error("step pulse while stopped");

    // a step advances the position by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && b2_valid_reg && pulse_next |=> count_reg == $past(count_reg) + 1'b1)
        else $error("step without position advance");

endmodule

// ----- design/stepper_speed_ramp_step_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_ramp_step_generator: pump stepper speed ramp and step generator
// Turns flow commands and timer ticks into a ramped speed and step pulses.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one command per transfer: s_tuser is the command
//   (tick, set flow, stop, clear position), s_tdata the flow rate and the
//   microseconds elapsed since the previous tick
//   m_channel returns one status transfer per command, in order: running
//   flag, step pulse, applied and target speed, step position
//   cfg_we / cfg_addr / cfg_wdata write flow gain, max speed and ramp rate;
//   write only while no command is in flight
// timing:
//   one command per cycle while m_tready holds high; a status passes
//   through three arithmetic stages in front, the queue, then the
//   ramp, product and phase stages in the back
//   the front and back are joined by a 4-entry queue, so intake keeps going
//   while the receiver stalls; once the queue is full, s_tready drops until
//   m_tready returns
// reset:
//   aresetn (synchronous) stops the pump, clears both speeds, the phase and
//   the position, empties the queue and loads the default register values
// ----------------------------------------------------------------------------
module stepper_speed_ramp_step_generator #(
    parameter int POSITION_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    // command channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // flow_rate[15:0], elapsed_us[31:16]
    input  logic [1:0]   s_tuser,   // cmd[1:0]
    // status channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // is_running[0], step_pulse[1], applied_speed[25:2], target_speed[49:26],
    // step_position[81:50], zero fill[87:82]
    output logic [87:0]  m_tdata
);

    ssrg_pkg::cfg_t     cfg_reg;
    ssrg_pkg::q_stat_t  q_stat;
    ssrg_pkg::work_t    push_data, pop_data;
    logic               push, pop;

    logic               out_running, out_pulse;
    logic [23:0]        out_applied, out_target;
    logic [31:0]        out_position;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flow_gain <= ssrg_pkg::FLOW_GAIN_RESET;
            cfg_reg.max_speed <= ssrg_pkg::MAX_SPEED_RESET;
            cfg_reg.ramp_rate <= ssrg_pkg::RAMP_RATE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ssrg_pkg::REG_FLOW_GAIN: cfg_reg.flow_gain <= cfg_wdata;
                ssrg_pkg::REG_MAX_SPEED: cfg_reg.max_speed <= cfg_wdata;
                ssrg_pkg::REG_RAMP_RATE: cfg_reg.ramp_rate <= cfg_wdata[15:0];
                default: ;  // unused index, write is dropped
            endcase
        end
    end

    // front: classify command, compute clamped target and ramp limit
    ssrg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_flow   (s_tdata[15:0]),
        .in_dt     (s_tdata[31:16]),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // queue decouples intake from the state update
    ssrg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // back: speed ramp, step phase, position and the status register
    ssrg_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .max_speed    (cfg_reg.max_speed),
        .q_stat       (q_stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_running  (out_running),
        .out_pulse    (out_pulse),
        .out_applied  (out_applied),
        .out_target   (out_target),
        .out_position (out_position)
    );

    // status packing, lowest field first
    assign m_tdata = {6'b0, out_position, out_target, out_applied, out_pulse, out_running};

endmodule
